// File: rtl/core/oli_pkg.sv
// Shared definitions for the ordered list block: sizes, request and status
// codes, and the command word broadcast to the cell chain. No dependencies.
`timescale 1ns / 1ps

package oli_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int CMP_W      = ((CNT_W > 5) ? CNT_W : 5) + 1;

	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_APPEND     = 3'd1;
	localparam logic [2:0] OP_INSERT_POS = 3'd2;
	localparam logic [2:0] OP_DEL_FIRST  = 3'd3;
	localparam logic [2:0] OP_DEL_LAST   = 3'd4;
	localparam logic [2:0] OP_DEL_POS    = 3'd5;
	localparam logic [2:0] OP_READ_OUT   = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_DEL  = 2'd2,
		CELL_ROT  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t               kind;
		logic [IDX_W-1:0]       slot;
		logic [DATA_WIDTH-1:0]  word;
		logic [CNT_W-1:0]       count;
	} cell_cmd_t;

endpackage

// File: rtl/core/oli_cell.sv
// One storage cell of the list chain. Holds a single entry and moves data
// from or to its neighbors as the broadcast command says. Uses oli_pkg.
`timescale 1ns / 1ps

module oli_cell (
	input  logic                          clk,
	input  oli_pkg::cell_cmd_t            cmd,
	input  logic [oli_pkg::IDX_W-1:0]     idx,
	input  logic [oli_pkg::DATA_WIDTH-1:0] left_data,
	input  logic [oli_pkg::DATA_WIDTH-1:0] right_data,
	input  logic [oli_pkg::DATA_WIDTH-1:0] front_data,
	output logic [oli_pkg::DATA_WIDTH-1:0] data_q
);
	import oli_pkg::*;

	logic [CNT_W-1:0] idx_next;

	assign idx_next = CNT_W'(idx) + CNT_W'(1);

	// A rotation moves the front entry to the last occupied cell.
	always_ff @(posedge clk) begin
		case (cmd.kind)
			CELL_INS: begin
				if (idx > cmd.slot) begin
					data_q <= left_data;
				end else if (idx == cmd.slot) begin
					data_q <= cmd.word;
				end
			end
			CELL_DEL: begin
				if (idx >= cmd.slot) begin
					data_q <= right_data;
				end
			end
			CELL_ROT: begin
				if (idx_next == cmd.count) begin
					data_q <= front_data;
				end else if (idx_next < cmd.count) begin
					data_q <= right_data;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/core/ordered_list_insert_delete.sv
// Top level of the ordered list block: request decode, output word register,
// readout sequencer and the chain of oli_cell instances. Uses oli_pkg.
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed entries, front first, kept in a row of
// cells that shift together. On every insert or delete the request is
// decoded, each cell at or beyond the target slot takes its neighbor's
// entry, and one result word with status and the new count is registered.
// A new request may be accepted every cycle while results keep draining
// and no readout runs. A readout of a non-empty list gives one result word
// per entry: the chain rotates by one entry per delivered word, so the list is
// back in its original order when the last word (last = 1) goes out, and the
// input stays stalled until then. Any request that fails (insert into a
// full list, delete from or readout of an empty list, a bad position) leaves
// the list unchanged and gives one word with the matching status. There is
// no clearing pass: the cells are not reset, only the count and control.
module ordered_list_insert_delete (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         op,
	input  logic signed [31:0] value,
	input  logic [4:0]         position,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] item,
	output logic [4:0]         count,
	output logic               last
);
	import oli_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} seq_state_t;

	function automatic logic [DATA_WIDTH-1:0] to_store(input logic [31:0] v);
		logic [63:0] e;
		e = {{32{v[31]}}, v};
		return e[DATA_WIDTH-1:0];
	endfunction

	function automatic logic [31:0] to_item(input logic [DATA_WIDTH-1:0] d);
		logic [63:0] e;
		e = 64'(d);
		return e[31:0];
	endfunction

	function automatic logic [4:0] to_count(input logic [CNT_W-1:0] c);
		logic [CMP_W-1:0] e;
		e = CMP_W'(c);
		return e[4:0];
	endfunction

	seq_state_t             state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       rd_left_q;
	logic                   out_valid_q;
	logic [1:0]             status_q;
	logic [31:0]            item_q;
	logic [4:0]             count_q;
	logic                   last_q;

	logic                   out_free;
	logic                   accept;
	logic                   rotate;
	logic                   is_full;
	logic                   is_empty;
	logic [CMP_W-1:0]       pos_w;
	logic [CMP_W-1:0]       cnt_w;
	logic [IDX_W-1:0]       pos_slot;
	logic [IDX_W-1:0]       cnt_slot;
	logic [1:0]             st_n;
	logic [CNT_W-1:0]       cnt_n;
	logic                   start_read;
	cell_cmd_t              cmd;
	logic [DATA_WIDTH-1:0]  cell_data [DEPTH];

	// The output word register parts the two sides: it may be refilled in
	// the same cycle in which its old word is taken.
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;
	assign rotate   = (state_q == S_READ) && out_free;

	assign is_full  = (cnt_q == CNT_W'(DEPTH));
	assign is_empty = (cnt_q == '0);
	assign pos_w    = CMP_W'(position);
	assign cnt_w    = CMP_W'(cnt_q);
	assign pos_slot = IDX_W'(pos_w - CMP_W'(1));
	assign cnt_slot = IDX_W'(cnt_q);

	// Request decode. Slots are 0-based; positions arrive 1-based.
	always_comb begin
		cmd.kind   = CELL_HOLD;
		cmd.slot   = '0;
		cmd.word   = to_store(value);
		cmd.count  = cnt_q;
		st_n       = ST_OK;
		cnt_n      = cnt_q;
		start_read = 1'b0;
		if (rotate) begin
			cmd.kind = CELL_ROT;
		end else if (accept) begin
			unique case (op) inside
				OP_PUSH_FRONT, OP_APPEND, OP_INSERT_POS: begin
					if (is_full) begin
						st_n = ST_FULL;
					end else if (op == OP_PUSH_FRONT) begin
						cmd.kind = CELL_INS;
						cmd.slot = '0;
					end else if (op == OP_APPEND) begin
						cmd.kind = CELL_INS;
						cmd.slot = cnt_slot;
					end else if (is_empty) begin
						// An empty list takes a positioned insert at any position.
						cmd.kind = CELL_INS;
						cmd.slot = '0;
					end else if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)) begin
						st_n = ST_RANGE;
					end else begin
						cmd.kind = CELL_INS;
						cmd.slot = pos_slot;
					end
					if (cmd.kind == CELL_INS) begin
						cnt_n = cnt_q + CNT_W'(1);
					end
				end
				OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_POS: begin
					if (is_empty) begin
						st_n = ST_EMPTY;
					end else if (op == OP_DEL_FIRST) begin
						cmd.kind = CELL_DEL;
						cmd.slot = '0;
					end else if (op == OP_DEL_LAST) begin
						cmd.kind = CELL_DEL;
						cmd.slot = IDX_W'(cnt_q - CNT_W'(1));
					end else if (pos_w == '0 || pos_w > cnt_w) begin
						st_n = ST_RANGE;
					end else begin
						cmd.kind = CELL_DEL;
						cmd.slot = pos_slot;
					end
					if (cmd.kind == CELL_DEL) begin
						cnt_n = cnt_q - CNT_W'(1);
					end
				end
				OP_READ_OUT: begin
					if (is_empty) begin
						st_n = ST_EMPTY;
					end else begin
						start_read = 1'b1;
					end
				end
				default: begin
					// The unused op code leaves the list as it is and gives an ok word.
				end
			endcase
		end
	end

	// Sequencer and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rd_left_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_n;
			unique case (state_q)
				S_IDLE: begin
					if (start_read) begin
						state_q   <= S_READ;
						rd_left_q <= cnt_q;
					end
					if (accept && !start_read) begin
						out_valid_q <= 1'b1;
					end else if (!out_stall) begin
						out_valid_q <= 1'b0;
					end
				end
				S_READ: begin
					if (rotate) begin
						out_valid_q <= 1'b1;
						rd_left_q   <= rd_left_q - CNT_W'(1);
						if (rd_left_q == CNT_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result word payload.
	always_ff @(posedge clk) begin
		if (rotate) begin
			status_q <= ST_OK;
			item_q   <= to_item(cell_data[0]);
			count_q  <= to_count(cnt_q);
			last_q   <= (rd_left_q == CNT_W'(1));
		end else if (accept && !start_read) begin
			status_q <= st_n;
			item_q   <= '0;
			count_q  <= to_count(cnt_n);
			last_q   <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign item      = item_q;
	assign count     = count_q;
	assign last      = last_q;

	// The chain of cells, entry 0 at the front.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d;
		logic [DATA_WIDTH-1:0] right_d;

		if (g == 0) begin : g_first
			assign left_d = cmd.word;
		end else begin : g_mid_l
			assign left_d = cell_data[g-1];
		end

		if (g == DEPTH - 1) begin : g_end
			assign right_d = cell_data[g];
		end else begin : g_mid_r
			assign right_d = cell_data[g+1];
		end

		oli_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.idx        (IDX_W'(g)),
			.left_data  (left_d),
			.right_data (right_d),
			.front_data (cell_data[0]),
			.data_q     (cell_data[g])
		);
	end

endmodule

// File: tb/ordered_list_insert_delete_tb.sv
// Self-checking testbench for ordered_list_insert_delete: a directed opening,
// then long runs of random list traffic checked against a local list predictor.
// Depends on oli_pkg and the ordered_list_insert_delete RTL only.
`timescale 1ns / 1ps

module ordered_list_insert_delete_tb;

	import oli_pkg::*;

	// Op code seven has no meaning in the block: it must change nothing and
	// answer with a single ok word.
	localparam logic [2:0] OP_UNUSED = 3'd7;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int LONG_HOLD    = 120;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_REQS  = 230;
	localparam int SETTLE_AT    = 150;

	// One request word as the driver will present it. When settle is set the
	// driver keeps it back until every predicted result word has come out.
	typedef struct {
		logic [2:0]         op;
		logic signed [31:0] value;
		logic [4:0]         position;
		bit                 settle;
	} list_request_t;

	// One result word as the block should deliver it.
	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] item;
		logic [4:0]         count;
		logic               last;
	} list_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         op = OP_PUSH_FRONT;
	logic signed [31:0] value = '0;
	logic [4:0]         position = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic signed [31:0] item;
	logic [4:0]         count;
	logic               last;

	ordered_list_insert_delete dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.value     (value),
		.position  (position),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.item      (item),
		.count     (count),
		.last      (last)
	);

	// Stimulus waiting to be driven, and result words predicted but not yet seen.
	list_request_t      request_q[$];
	list_result_t       due_results[$];

	// The predictor's own copy of the list, front at index zero.
	logic signed [31:0] list_words[DEPTH];
	int                 list_len = 0;

	// Entry count as the stimulus generator expects it; only used to steer
	// positions and the grow / shrink phases, never for checking.
	int                 plan_len = 0;

	int                 total_requests = 0;
	int                 words_sent = 0;
	int                 words_checked = 0;
	int                 mismatches = 0;
	int                 cycles = 0;
	int                 status_seen[4] = '{0, 0, 0, 0};

	int                 idle_left = 0;
	int                 burst_left = 0;
	int                 hold_left = 0;
	int                 stall_tick = 0;
	bit                 long_hold_done = 1'b0;
	list_request_t      next_req;
	list_result_t       want;

	// Op mix for the random part. In a grow phase inserts dominate so the list
	// runs up to full; in a shrink phase deletes dominate so it drains to empty.
	logic [2:0] op_menu[7] = '{OP_PUSH_FRONT, OP_APPEND, OP_INSERT_POS, OP_DEL_FIRST,
		OP_DEL_LAST, OP_DEL_POS, OP_READ_OUT};
	int grow_cut[7]   = '{25, 50, 72, 78, 84, 90, 97};
	int shrink_cut[7] = '{6, 12, 18, 38, 58, 88, 97};
	logic signed [31:0] corner_words[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
		32'hffff_ffff};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH cycle %0d: %s", cycles, what);
		mismatches++;
	endtask

	// Queues one request and tracks the entry count the generator expects.
	task automatic queue_request(input logic [2:0] rop, input logic signed [31:0] rval,
		input logic [4:0] rpos, input bit settle = 1'b0);
		list_request_t req;
		req.op = rop;
		req.value = rval;
		req.position = rpos;
		req.settle = settle;
		request_q.push_back(req);
		case (rop) inside
			OP_PUSH_FRONT, OP_APPEND, OP_INSERT_POS: begin
				if (plan_len < DEPTH && (rop != OP_INSERT_POS || plan_len == 0 ||
					(rpos >= 1 && rpos <= plan_len + 1)))
					plan_len++;
			end
			OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_POS: begin
				if (plan_len > 0 && (rop != OP_DEL_POS || (rpos >= 1 && rpos <= plan_len)))
					plan_len--;
			end
			default: ;
		endcase
	endtask

	// Applies one accepted request to the predicted list and queues the result
	// words it must produce. A failed request leaves the list alone and gives one
	// word; a readout of a non-empty list gives one word per entry, front first.
	task automatic apply_request(input logic [2:0] rop, input logic signed [31:0] rval,
		input logic [4:0] rpos);
		int           slot;
		int           i;
		logic [1:0]   st;
		list_result_t res;
		st = ST_OK;
		slot = -1;
		case (rop) inside
			OP_PUSH_FRONT, OP_APPEND, OP_INSERT_POS: begin
				// Full wins over a bad position, and an empty list takes a
				// positioned insert whatever the position says.
				if (list_len >= DEPTH)
					st = ST_FULL;
				else if (rop == OP_PUSH_FRONT || list_len == 0)
					slot = 0;
				else if (rop == OP_APPEND)
					slot = list_len;
				else if (rpos == 0 || rpos > list_len + 1)
					st = ST_RANGE;
				else
					slot = rpos - 1;
				if (slot >= 0) begin
					for (i = list_len; i > slot; i--)
						list_words[i] = list_words[i - 1];
					list_words[slot] = rval;
					list_len++;
				end
			end
			OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_POS: begin
				if (list_len == 0)
					st = ST_EMPTY;
				else if (rop == OP_DEL_FIRST)
					slot = 0;
				else if (rop == OP_DEL_LAST)
					slot = list_len - 1;
				else if (rpos == 0 || rpos > list_len)
					st = ST_RANGE;
				else
					slot = rpos - 1;
				if (slot >= 0) begin
					for (i = slot; i < list_len - 1; i++)
						list_words[i] = list_words[i + 1];
					list_len--;
				end
			end
			OP_READ_OUT: begin
				if (list_len == 0) begin
					st = ST_EMPTY;
				end else begin
					for (i = 0; i < list_len; i++) begin
						res.status = ST_OK;
						res.item = list_words[i];
						res.count = list_len[4:0];
						res.last = (i == list_len - 1);
						due_results.push_back(res);
					end
					return;
				end
			end
			default: ;
		endcase
		res.status = st;
		res.item = '0;
		res.count = list_len[4:0];
		res.last = 1'b1;
		due_results.push_back(res);
	endtask

	// Driver. Every accepted word goes to the predictor at the edge that takes
	// it. A stalled word is held unchanged; otherwise the next word is offered
	// unless an idle gap is running or the head of the queue asks to wait for
	// all outstanding results. Bursts of random length alternate with gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= OP_PUSH_FRONT;
			value <= '0;
			position <= '0;
			idle_left <= 0;
			burst_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				apply_request(op, value, position);
				words_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (idle_left > 0) begin
					in_valid <= 1'b0;
					idle_left <= idle_left - 1;
				end else if (request_q.size() > 0 &&
					!(request_q[0].settle && due_results.size() != 0)) begin
					next_req = request_q.pop_front();
					in_valid <= 1'b1;
					op <= next_req.op;
					value <= next_req.value;
					position <= next_req.position;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						idle_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall pattern. It cycles through open, light, heavy and periodic
	// stalling. Once, well into the run, it holds off for a long stretch so the
	// output word backs up and the block must stall its input while the driver
	// keeps offering.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			long_hold_done <= 1'b0;
			stall_tick <= 0;
		end else begin
			stall_tick <= stall_tick + 1;
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (!long_hold_done && words_sent >= 100) begin
				out_stall <= 1'b1;
				hold_left <= LONG_HOLD;
				long_hold_done <= 1'b1;
			end else begin
				case ((stall_tick / 97) % 4)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= (stall_tick % 3 == 0);
				endcase
			end
		end
	end

	// Monitor. Each word taken from the block is compared field by field with
	// the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			words_checked++;
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("word with nothing due: status %0d item %0d count %0d last %0b",
					status, item, count, last));
			end else begin
				want = due_results.pop_front();
				status_seen[want.status]++;
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", status, want.status));
				if (item !== want.item)
					report_mismatch($sformatf("item %0d, want %0d", item, want.item));
				if (count !== want.count)
					report_mismatch($sformatf("count %0d, want %0d", count, want.count));
				if (last !== want.last)
					report_mismatch($sformatf("last %0b, want %0b", last, want.last));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Run stopped at cycle %0d with %0d words still due", cycles,
				due_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int                 n;
		int                 r;
		int                 k;
		bit                 grow;
		logic [2:0]         pick;
		logic [4:0]         rpos;
		logic signed [31:0] rval;

		// Directed opening: the empty status from a readout and from each delete
		// on an empty list, the meaningless op, a positioned insert into an empty
		// list, inserts at the front, at the back and in the middle, out-of-range
		// positions on both sides, readouts, and deletes until the list is empty.
		queue_request(OP_READ_OUT, 32'h1234_5678, 5'd0);
		queue_request(OP_DEL_FIRST, 32'h0, 5'd1);
		queue_request(OP_DEL_LAST, 32'h0, 5'd1);
		queue_request(OP_DEL_POS, 32'h0, 5'd31);
		queue_request(OP_INSERT_POS, 32'h8000_0000, 5'd0);
		queue_request(OP_UNUSED, 32'hffff_ffff, 5'd31);
		queue_request(OP_PUSH_FRONT, 32'h7fff_ffff, 5'd0);
		queue_request(OP_APPEND, 32'hffff_ffff, 5'd0);
		queue_request(OP_INSERT_POS, 32'h0000_0000, 5'd1);
		queue_request(OP_INSERT_POS, 32'h0000_3039, 5'd5);
		queue_request(OP_INSERT_POS, 32'h0bad_0bad, 5'd0);
		queue_request(OP_INSERT_POS, 32'h0bad_0bad, 5'd7);
		queue_request(OP_INSERT_POS, 32'h55aa_55aa, 5'd3);
		queue_request(OP_READ_OUT, 32'h0, 5'd0);
		queue_request(OP_DEL_POS, 32'h0, 5'd0);
		queue_request(OP_DEL_POS, 32'h0, 5'd7);
		queue_request(OP_DEL_POS, 32'h0, 5'd1);
		queue_request(OP_DEL_POS, 32'h0, 5'd5);
		queue_request(OP_DEL_LAST, 32'h0, 5'd0);
		queue_request(OP_DEL_FIRST, 32'h0, 5'd0);
		queue_request(OP_DEL_POS, 32'h0, 5'd2);
		queue_request(OP_READ_OUT, 32'h0, 5'd0);
		queue_request(OP_DEL_FIRST, 32'h0, 5'd0);
		queue_request(OP_READ_OUT, 32'h0, 5'd0);

		// Random part: alternating grow and shrink phases so the list keeps
		// passing through full and empty. Most positions are in range; the rest
		// cover the whole five-bit field. A phase only turns after a few hits on
		// the full or empty boundary.
		grow = 1'b1;
		for (n = 0; n < RANDOM_REQS; n++) begin
			r = $urandom_range(0, 99);
			pick = OP_UNUSED;
			for (k = 6; k >= 0; k--)
				if (r < (grow ? grow_cut[k] : shrink_cut[k]))
					pick = op_menu[k];
			rpos = 5'($urandom_range(0, 31));
			if (pick == OP_INSERT_POS && $urandom_range(0, 99) < 85)
				rpos = 5'($urandom_range(1, plan_len + 1));
			else if (pick == OP_DEL_POS && plan_len > 0 && $urandom_range(0, 99) < 85)
				rpos = 5'($urandom_range(1, plan_len));
			rval = ($urandom_range(0, 9) == 0) ? corner_words[$urandom_range(0, 3)] : $urandom;
			queue_request(pick, rval, rpos, n == SETTLE_AT);
			if (grow && plan_len == DEPTH && $urandom_range(0, 2) == 0)
				grow = 1'b0;
			else if (!grow && plan_len == 0 && $urandom_range(0, 2) == 0)
				grow = 1'b1;
		end
		total_requests = request_q.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (words_sent < total_requests)
			@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d list requests and checked %0d result words in %0d cycles.",
			words_sent, words_checked, cycles);
		$display("Status words seen: ok %0d, full %0d, empty %0d, out of range %0d.",
			status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
			status_seen[ST_RANGE]);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: ordered_list_insert_delete.f
rtl/core/oli_pkg.sv
rtl/core/oli_cell.sv
rtl/core/ordered_list_insert_delete.sv
tb/ordered_list_insert_delete_tb.sv
